// ===== design/hilbert_index_nd_transform_macros.svh =====
// ----------------------------------------------------------------------------
// Hilbert index transform assertion macros
// Shared concurrent assertion templates for the Hilbert index transform.
// ----------------------------------------------------------------------------
`ifndef HILBERT_INDEX_ND_TRANSFORM_MACROS_SVH
`define HILBERT_INDEX_ND_TRANSFORM_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define HILB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HILB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/hilb_pkg.sv =====
// ----------------------------------------------------------------------------
// Hilbert index transform package
// Field widths, register indexes, command codes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package hilb_pkg;

   localparam int DEF_MAX_DIMENSIONS = 4;
   localparam int DEF_MAX_ORDER      = 16;

   localparam int COORD_W     = 16;
   localparam int INDEX_W     = 64;
   localparam int DIM_REG_W   = 3;
   localparam int ORDER_REG_W = 5;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_ADDR_W-1:0] REG_DIMENSIONS  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_CURVE_ORDER = 2'd1;

   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

endpackage

`default_nettype wire

// ===== design/hilb_req_if.sv =====
// ----------------------------------------------------------------------------
// Hilbert request channel
// Valid/ready channel carrying one conversion request.
// ----------------------------------------------------------------------------
`default_nettype none

interface hilb_req_if;
   logic                         valid;
   logic                         ready;
   logic                         cmd;
   logic [hilb_pkg::COORD_W-1:0] coord_0;
   logic [hilb_pkg::COORD_W-1:0] coord_1;
   logic [hilb_pkg::COORD_W-1:0] coord_2;
   logic [hilb_pkg::COORD_W-1:0] coord_3;
   logic [hilb_pkg::INDEX_W-1:0] index;

   modport source (output valid, cmd, coord_0, coord_1, coord_2, coord_3, index,
                   input ready);
   modport sink (input valid, cmd, coord_0, coord_1, coord_2, coord_3, index,
                 output ready);
endinterface

`default_nettype wire

// ===== design/hilb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Hilbert response channel
// Valid/ready channel carrying one conversion result.
// ----------------------------------------------------------------------------
`default_nettype none

interface hilb_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hilb_pkg::INDEX_W-1:0] out_index;
   logic [hilb_pkg::COORD_W-1:0] out_coord_0;
   logic [hilb_pkg::COORD_W-1:0] out_coord_1;
   logic [hilb_pkg::COORD_W-1:0] out_coord_2;
   logic [hilb_pkg::COORD_W-1:0] out_coord_3;

   modport source (output valid, out_index, out_coord_0, out_coord_1, out_coord_2,
                   out_coord_3, input ready);
   modport sink (input valid, out_index, out_coord_0, out_coord_1, out_coord_2,
                 out_coord_3, output ready);
endinterface

`default_nettype wire

// ===== design/hilb_csr_if.sv =====
// ----------------------------------------------------------------------------
// Hilbert configuration channel
// Valid/ready register write channel with index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface hilb_csr_if;
   logic                            valid;
   logic                            ready;
   logic [hilb_pkg::CSR_ADDR_W-1:0] index;
   logic [hilb_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/hilb_digit.sv =====
// ----------------------------------------------------------------------------
// Hilbert digit step unit
// Shared per-digit transform: Gray coding, rotation, entry mask and direction.
// ----------------------------------------------------------------------------
`default_nettype none

module hilb_digit #(
   parameter int  MAX_DIMENSIONS = hilb_pkg::DEF_MAX_DIMENSIONS,
   localparam int DIG_W          = MAX_DIMENSIONS,
   localparam int DCNT_W         = $clog2(MAX_DIMENSIONS + 1),
   localparam int ROT_W          = $clog2(MAX_DIMENSIONS)
) (
   input  logic [DCNT_W-1:0] dims,
   input  logic              decode,
   input  logic [DIG_W-1:0]  digit_src,
   input  logic [DIG_W-1:0]  w_cur,
   input  logic [ROT_W-1:0]  xj_cur,
   output logic [DIG_W-1:0]  digit_res,
   output logic [DIG_W-1:0]  w_upd,
   output logic [ROT_W-1:0]  xj_upd
);

   function automatic logic [DIG_W-1:0] rotr(input logic [DIG_W-1:0] v,
                                             input logic [ROT_W-1:0] r,
                                             input logic [DCNT_W-1:0] n);
      logic [DIG_W-1:0] res;
      int               src;
      res = '0;
      for (int j = 0; j < DIG_W; j++) begin
         src = j + int'(r);
         if (src >= int'(n)) begin
            src = src - int'(n);
         end
         for (int s = 0; s < DIG_W; s++) begin
            if (j < int'(n) && s == src) begin
               res[j] = v[s];
            end
         end
      end
      return res;
   endfunction

   logic [DIG_W-1:0] mask;
   logic [ROT_W-1:0] rot_left;
   logic [DIG_W-1:0] s_enc;
   logic [DIG_W-1:0] p_enc;
   logic [DIG_W-1:0] p_dec;
   logic [DIG_W-1:0] a_dec;
   logic [DIG_W-1:0] p_sel;
   logic [DIG_W-1:0] q_val;
   logic [DIG_W-1:0] t_val;
   int               i_first;
   int               j_val;
   int               sum;

   always_comb begin
      for (int j = 0; j < DIG_W; j++) begin
         mask[j] = (j < int'(dims));
      end

      if (xj_cur == '0) begin
         rot_left = '0;
      end else begin
         rot_left = ROT_W'(DCNT_W'(dims) - DCNT_W'(xj_cur));
      end

      s_enc = rotr((digit_src ^ w_cur) & mask, rot_left, dims);
      for (int j = 0; j < DIG_W; j++) begin
         p_enc[j] = 1'b0;
         for (int k = 0; k < DIG_W; k++) begin
            if (k >= j) begin
               p_enc[j] = p_enc[j] ^ s_enc[k];
            end
         end
      end

      p_dec = digit_src & mask;
      a_dec = w_cur ^ rotr(p_dec ^ (p_dec >> 1), xj_cur, dims);

      p_sel     = decode ? p_dec : p_enc;
      digit_res = decode ? a_dec : p_enc;

      q_val = p_sel[0] ? (p_sel - DIG_W'(1)) : (p_sel - DIG_W'(2));
      if (int'(p_sel) <= 2) begin
         t_val = '0;
      end else begin
         t_val = q_val ^ (q_val >> 1);
      end
      w_upd = w_cur ^ rotr(t_val, xj_cur, dims);

      i_first = int'(dims);
      for (int i = DIG_W - 1; i >= 1; i--) begin
         if (i < int'(dims) && p_sel[i] != p_sel[0]) begin
            i_first = i;
         end
      end
      j_val = (i_first == int'(dims)) ? int'(dims) : int'(dims) - i_first;
      sum   = int'(xj_cur) + j_val - 1;
      if (sum >= int'(dims)) begin
         sum = sum - int'(dims);
      end
      xj_upd = ROT_W'(sum);
   end

endmodule

`default_nettype wire

// ===== design/hilbert_index_nd_transform.sv =====
// ----------------------------------------------------------------------------
// Hilbert index transform, n-dimensional, both directions
// Requests are accepted only in idle; the single digit step unit then handles
// one index digit per cycle in the run state, and a new request is not taken
// until the result has been parked and the sequencer is back in idle.
// The response register frees the sequencer once the result is parked.
// Synchronous active-high reset: dimensions = 2, curve_order = 16, idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hilbert_index_nd_transform_macros.svh"

module hilbert_index_nd_transform #(
   parameter int MAX_DIMENSIONS = hilb_pkg::DEF_MAX_DIMENSIONS,
   parameter int MAX_ORDER      = hilb_pkg::DEF_MAX_ORDER
) (
   input logic          clock,
   input logic          reset,
   hilb_req_if.sink     req_chan,
   hilb_rsp_if.source   rsp_chan,
   hilb_csr_if.sink     csr_chan
);

   localparam int DIG_W   = MAX_DIMENSIONS;
   localparam int DCNT_W  = $clog2(MAX_DIMENSIONS + 1);
   localparam int ROT_W   = $clog2(MAX_DIMENSIONS);
   localparam int ORD_W   = MAX_ORDER;
   localparam int BIT_W   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int MCNT_W  = $clog2(MAX_ORDER + 1);
   localparam int SH_W    = $clog2(MAX_DIMENSIONS * MAX_ORDER);
   localparam int COORD_W = hilb_pkg::COORD_W;
   localparam int INDEX_W = hilb_pkg::INDEX_W;
   localparam int EXT_W   = (ORD_W > COORD_W) ? ORD_W : COORD_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                         state_ff, state_in;
   logic [hilb_pkg::DIM_REG_W-1:0]     dims_ff, dims_in;
   logic [hilb_pkg::ORDER_REG_W-1:0]   order_ff, order_in;
   logic [DCNT_W-1:0]                  n_ff, n_in;
   logic                               decode_ff, decode_in;
   logic [BIT_W-1:0]                   bit_ff, bit_in;
   logic [SH_W-1:0]                    sh_ff, sh_in;
   logic [DIG_W-1:0]                   w_ff, w_in;
   logic [ROT_W-1:0]                   xj_ff, xj_in;
   logic [ORD_W-1:0]                   coord_ff [MAX_DIMENSIONS];
   logic [ORD_W-1:0]                   coord_in [MAX_DIMENSIONS];
   logic [INDEX_W-1:0]                 index_ff, index_in;
   logic [INDEX_W-1:0]                 acc_ff, acc_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]                 rsp_index_ff, rsp_index_in;
   logic [COORD_W-1:0]                 rsp_coord_ff [4];
   logic [COORD_W-1:0]                 rsp_coord_in [4];

   logic                               req_fire;
   logic                               out_free;
   logic [COORD_W-1:0]                 req_coord [4];
   logic [ORD_W-1:0]                   coord_pad [4];
   logic [DCNT_W-1:0]                  n_eff;
   logic [MCNT_W-1:0]                  m_eff;
   logic [DIG_W-1:0]                   a_enc;
   logic [INDEX_W-1:0]                 p_word;
   logic [DIG_W-1:0]                   digit_src;
   logic [DIG_W-1:0]                   digit_res;
   logic [DIG_W-1:0]                   w_upd;
   logic [ROT_W-1:0]                   xj_upd;
   logic                               shift_bit;

   assign req_coord[0] = req_chan.coord_0;
   assign req_coord[1] = req_chan.coord_1;
   assign req_coord[2] = req_chan.coord_2;
   assign req_coord[3] = req_chan.coord_3;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_index   = rsp_index_ff;
   assign rsp_chan.out_coord_0 = rsp_coord_ff[0];
   assign rsp_chan.out_coord_1 = rsp_coord_ff[1];
   assign rsp_chan.out_coord_2 = rsp_coord_ff[2];
   assign rsp_chan.out_coord_3 = rsp_coord_ff[3];

   hilb_digit #(
      .MAX_DIMENSIONS (MAX_DIMENSIONS)
   ) u_digit (
      .dims      (n_ff),
      .decode    (decode_ff),
      .digit_src (digit_src),
      .w_cur     (w_ff),
      .xj_cur    (xj_ff),
      .digit_res (digit_res),
      .w_upd     (w_upd),
      .xj_upd    (xj_upd)
   );

   always_comb begin
      if (dims_ff < hilb_pkg::DIM_REG_W'(2)) begin
         n_eff = DCNT_W'(2);
      end else if (int'(dims_ff) > MAX_DIMENSIONS) begin
         n_eff = DCNT_W'(MAX_DIMENSIONS);
      end else begin
         n_eff = DCNT_W'(dims_ff);
      end

      if (order_ff == '0) begin
         m_eff = MCNT_W'(1);
      end else if (int'(order_ff) > MAX_ORDER) begin
         m_eff = MCNT_W'(MAX_ORDER);
      end else begin
         m_eff = MCNT_W'(order_ff);
      end

      a_enc = '0;
      for (int k = 0; k < MAX_DIMENSIONS; k++) begin
         for (int j = 0; j < DIG_W; j++) begin
            if (k + j == int'(n_ff) - 1) begin
               a_enc[j] = coord_ff[k][bit_ff];
            end
         end
      end

      p_word = index_ff >> sh_ff;
      if (int'(sh_ff) >= INDEX_W) begin
         digit_src = decode_ff ? '0 : a_enc;
      end else begin
         digit_src = decode_ff ? p_word[DIG_W-1:0] : a_enc;
      end

      for (int k = 0; k < 4; k++) begin
         coord_pad[k] = '0;
      end
      for (int k = 0; k < MAX_DIMENSIONS; k++) begin
         coord_pad[k] = coord_ff[k];
      end
   end

   always_comb begin
      state_in     = state_ff;
      dims_in      = dims_ff;
      order_in     = order_ff;
      n_in         = n_ff;
      decode_in    = decode_ff;
      bit_in       = bit_ff;
      sh_in        = sh_ff;
      w_in         = w_ff;
      xj_in        = xj_ff;
      index_in     = index_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      shift_bit    = 1'b0;
      for (int k = 0; k < MAX_DIMENSIONS; k++) begin
         coord_in[k] = coord_ff[k];
      end
      for (int k = 0; k < 4; k++) begin
         rsp_coord_in[k] = rsp_coord_ff[k];
      end

      if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            hilb_pkg::REG_DIMENSIONS: begin
               dims_in = csr_chan.data[hilb_pkg::DIM_REG_W-1:0];
            end
            hilb_pkg::REG_CURVE_ORDER: begin
               order_in = csr_chan.data[hilb_pkg::ORDER_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in  = ST_RUN;
               n_in      = n_eff;
               decode_in = (req_chan.cmd == hilb_pkg::CMD_DECODE);
               bit_in    = BIT_W'(int'(m_eff) - 1);
               sh_in     = SH_W'(int'(n_eff) * (int'(m_eff) - 1));
               w_in      = '0;
               xj_in     = '0;
               index_in  = req_chan.index;
               acc_in    = '0;
               for (int k = 0; k < MAX_DIMENSIONS; k++) begin
                  if (req_chan.cmd == hilb_pkg::CMD_DECODE) begin
                     coord_in[k] = '0;
                  end else begin
                     coord_in[k] = ORD_W'(EXT_W'(req_coord[k]));
                  end
               end
            end
         end
         ST_RUN: begin
            w_in  = w_upd;
            xj_in = xj_upd;
            bit_in = bit_ff - BIT_W'(1);
            sh_in  = sh_ff - SH_W'(n_ff);
            if (decode_ff) begin
               for (int k = 0; k < MAX_DIMENSIONS; k++) begin
                  shift_bit = 1'b0;
                  for (int j = 0; j < DIG_W; j++) begin
                     if (k + j == int'(n_ff) - 1) begin
                        shift_bit = digit_res[j];
                     end
                  end
                  coord_in[k] = (coord_ff[k] << 1) | ORD_W'(shift_bit);
               end
            end else begin
               acc_in = (acc_ff << n_ff) | INDEX_W'(digit_res);
            end
            if (bit_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_index_in = decode_ff ? '0 : acc_ff;
               for (int k = 0; k < 4; k++) begin
                  rsp_coord_in[k] = decode_ff ? COORD_W'(EXT_W'(coord_pad[k])) : '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dims_ff      <= hilb_pkg::DIM_REG_W'(2);
         order_ff     <= hilb_pkg::ORDER_REG_W'(16);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dims_ff      <= dims_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      decode_ff    <= decode_in;
      bit_ff       <= bit_in;
      sh_ff        <= sh_in;
      w_ff         <= w_in;
      xj_ff        <= xj_in;
      index_ff     <= index_in;
      acc_ff       <= acc_in;
      rsp_index_ff <= rsp_index_in;
      for (int k = 0; k < MAX_DIMENSIONS; k++) begin
         coord_ff[k] <= coord_in[k];
      end
      for (int k = 0; k < 4; k++) begin
         rsp_coord_ff[k] <= rsp_coord_in[k];
      end
   end

   `HILB_ASSERT_NEXT(a_accept_starts_run, clock, reset, req_fire, state_ff == ST_RUN, "Accepted transaction did not start the digit sequence.")
   `HILB_ASSERT_SAME(a_xj_in_range, clock, reset, state_ff == ST_RUN, DCNT_W'(xj_ff) < n_ff, "Direction count left its range.")
   `HILB_ASSERT_SAME(a_rsp_one_direction, clock, reset, rsp_chan.valid && rsp_chan.out_index != '0, (rsp_chan.out_coord_0 | rsp_chan.out_coord_1 | rsp_chan.out_coord_2 | rsp_chan.out_coord_3) == '0, "Response carries both an index and coordinates.")
   `HILB_ASSERT_NEXT(a_done_loads_rsp, clock, reset, state_ff == ST_DONE && out_free, rsp_valid_ff && state_ff == ST_IDLE, "Finished result was not loaded into the response register.")

endmodule

`default_nettype wire
